// File: sv/ccf_pkg.sv
// Shared types, constants and byte functions for the case-swap CRC-8 framer.
package ccf_pkg;

  localparam logic [7:0] CaseDelta = 8'd32;
  localparam logic [7:0] CrcPoly   = 8'h8C;  // 0x31 reflected
  localparam logic [7:0] CrcInit   = 8'h00;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChTerm    = 8'h00;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [7:0] crc_next;
    logic       frozen_next;
  } proc_t;

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + CaseDelta;
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CrcPoly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// File: sv/ccf_byte_proc.sv
// Per-byte logic: case swap, CRC step, freeze on CR/LF, terminator result.
module ccf_byte_proc import ccf_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic [7:0] crc_i,
  input  logic       frozen_i,
  output proc_t      res_o
);

  logic [7:0] swapped;

  always_comb begin
    swapped = swap_case(byte_i);
    res_o = '0;
    if (byte_i == ChTerm) begin
      res_o.out_byte    = crc_i;
      res_o.byte_valid  = (crc_i != CrcInit);
      res_o.last        = 1'b1;
      res_o.crc_next    = CrcInit;
      res_o.frozen_next = 1'b0;
    end else begin
      res_o.out_byte    = swapped;
      res_o.byte_valid  = 1'b1;
      res_o.last        = 1'b0;
      res_o.crc_next    = crc_i;
      res_o.frozen_next = frozen_i;
      if (!frozen_i) begin
        if (swapped == ChCr || swapped == ChLf) begin
          res_o.frozen_next = 1'b1;
        end else begin
          res_o.crc_next = crc8_update(crc_i, swapped);
        end
      end
    end
  end

endmodule

// File: sv/case_swap_crc8_framer.sv
// Top level of the case-swap CRC-8/MAXIM framer.
//
// Input channel: one message byte per item on data_byte_i (in_valid_i /
// in_ready_o). A zero byte terminates the message.
// Output channel: one result per input item (out_valid_o / out_ready_i):
// the case-swapped byte, or on the terminator the CRC byte with last_o set.
// byte_valid_o is low only for a zero CRC on the terminator.
// The CRC covers bytes up to the first CR or LF and restarts after each
// terminator.
// Path: each accepted byte is registered in the input register, then its result
// in the result register. Throughput: one item per cycle while the receiver
// does not stall, with the combinational CRC step between the two registers.
// When the receiver stalls, the result register holds and the input
// register takes one more item; in_ready_o drops once both are full.
// Reset empties both registers and clears the CRC and the freeze flag.
module case_swap_crc8_framer import ccf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  logic       last_q;
  logic [7:0] crc_q;
  logic       frozen_q;
  logic       in_acc;
  logic       out_load;
  proc_t      res;

  ccf_byte_proc u_proc (
    .byte_i   (s1_byte_q),
    .crc_i    (crc_q),
    .frozen_i (frozen_q),
    .res_o    (res)
  );

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= CrcInit;
      frozen_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        crc_q    <= res.crc_next;
        frozen_q <= res.frozen_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
    end
    if (out_load) begin
      out_byte_q   <= res.out_byte;
      byte_valid_q <= res.byte_valid;
      last_q       <= res.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  // terminator leaves the CRC state cleared
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && s1_byte_q == ChTerm) |=> (crc_q == CrcInit && !frozen_q))
    else $error("CRC state not cleared after terminator");

  // a suppressed byte is only ever a zero CRC on the terminator
  a_invalid_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (last_o && out_byte_o == CrcInit))
    else $error("byte_valid low outside a zero-CRC terminator");

  // input stalls only when both registers are full and the sink stalls
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without back-pressure");

  // freeze flag holds until a terminator passes
  a_frozen_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frozen_q && !(out_load && s1_byte_q == ChTerm)) |=> frozen_q)
    else $error("freeze flag dropped before terminator");

  // CRC does not move while frozen except on terminator
  a_crc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frozen_q && !(out_load && s1_byte_q == ChTerm)) |=> $stable(crc_q))
    else $error("CRC changed while frozen");
`endif

endmodule

// File: tb/sv/tb_case_swap_crc8_framer.sv
// Testbench for the case-swap CRC-8/MAXIM framer: directed table, random messages, scoreboard.
module tb_case_swap_crc8_framer;
  import ccf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 210;
  localparam int DirectedLen = 27;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
  } dir_row_t;

  logic       clk;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       last_o;

  // predictor state
  logic [7:0] crc_run  = CrcInit;
  logic       crc_hold = 1'b0;

  frame_res_t frame_q[$];
  int         err_count    = 0;
  int         items_sent   = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  bit         hold_off_armed = 1'b0;
  int         cyc_count    = 0;

  // typed rows: empty message, case edges, freeze, known table entries, zero CRC
  dir_row_t directed_tab [DirectedLen] = '{
    '{8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
    '{8'h41, 1'b1, 8'h61, 1'b1, 1'b0},
    '{8'h5A, 1'b1, 8'h7A, 1'b1, 1'b0},
    '{8'h61, 1'b1, 8'h41, 1'b1, 1'b0},
    '{8'h7A, 1'b1, 8'h5A, 1'b1, 1'b0},
    '{8'h40, 1'b1, 8'h40, 1'b1, 1'b0},
    '{8'h5B, 1'b1, 8'h5B, 1'b1, 1'b0},
    '{8'h60, 1'b1, 8'h60, 1'b1, 1'b0},
    '{8'h7B, 1'b1, 8'h7B, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{8'h0D, 1'b1, 8'h0D, 1'b1, 1'b0},
    '{8'h41, 1'b1, 8'h61, 1'b1, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b1, 8'h01, 1'b1, 1'b0},
    '{8'h00, 1'b1, 8'h5E, 1'b1, 1'b1},
    '{8'h02, 1'b1, 8'h02, 1'b1, 1'b0},
    '{8'h00, 1'b1, 8'hBC, 1'b1, 1'b1},
    '{8'h01, 1'b1, 8'h01, 1'b1, 1'b0},
    '{8'h5E, 1'b1, 8'h5E, 1'b1, 1'b0},
    '{8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
    '{8'h0A, 1'b1, 8'h0A, 1'b1, 1'b0},
    '{8'h80, 1'b1, 8'h80, 1'b1, 1'b0},
    '{8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
    '{8'h7F, 1'b1, 8'h7F, 1'b1, 1'b0},
    '{8'h0D, 1'b1, 8'h0D, 1'b1, 1'b0},
    '{8'h0A, 1'b1, 8'h0A, 1'b1, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  case_swap_crc8_framer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + CaseDelta;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

  // advances the predictor by one byte and returns the framed byte it produces
  function automatic frame_res_t frame_byte(input logic [7:0] b);
    frame_res_t r;
    logic [7:0] s;
    logic [7:0] v;
    if (b == ChTerm) begin
      r.out_byte   = crc_run;
      r.byte_valid = (crc_run != 8'h00);
      r.is_last    = 1'b1;
      crc_run      = CrcInit;
      crc_hold     = 1'b0;
    end else begin
      s = flip_case(b);
      if (!crc_hold) begin
        if (s == ChCr || s == ChLf) begin
          crc_hold = 1'b1;
        end else begin
          v = crc_run ^ s;
          for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
          end
          crc_run = v;
        end
      end
      r.out_byte   = s;
      r.byte_valid = 1'b1;
      r.is_last    = 1'b0;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_res_t typed_res);
    frame_res_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    pred = frame_byte(b);
    frame_q.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(19))
      0: b = $urandom_range(1) ? ChCr : ChLf;
      1, 2, 3, 4, 5, 6, 7, 8:
        b = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
      default: b = 8'($urandom_range(255, 1));
    endcase
    return b;
  endfunction

  task automatic send_message();
    int         len;
    logic [7:0] fix;
    len = ($urandom_range(15) == 0) ? $urandom_range(60, 25) : $urandom_range(10);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), 1'b0, '0);
    end
    // sometimes close the message with the byte that drives the CRC to zero
    if (!crc_hold && crc_run != 8'h00 && crc_run != ChCr && crc_run != ChLf &&
        $urandom_range(3) == 0) begin
      fix = flip_case(crc_run);
      send_byte(fix, 1'b0, '0);
    end
    send_byte(ChTerm, 1'b0, '0);
  endtask

  // receiver: checks results, then picks ready for the next cycle
  initial begin
    frame_res_t exp_res;
    int         hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (frame_q.size() == 0) begin
          $display("%0t ERROR unexpected item: expected none, actual %02h/%0b/%0b",
                   $time, out_byte_o, byte_valid_o, last_o);
          err_count++;
        end else begin
          exp_res = frame_q.pop_front();
          if (out_byte_o !== exp_res.out_byte) begin
            $display("%0t ERROR out_byte: expected %02h, actual %02h",
                     $time, exp_res.out_byte, out_byte_o);
            err_count++;
          end
          if (byte_valid_o !== exp_res.byte_valid) begin
            $display("%0t ERROR byte_valid: expected %0b, actual %0b",
                     $time, exp_res.byte_valid, byte_valid_o);
            err_count++;
          end
          if (last_o !== exp_res.is_last) begin
            $display("%0t ERROR last: expected %0b, actual %0b",
                     $time, exp_res.is_last, last_o);
            err_count++;
          end
        end
      end
      if (hold_off_armed) begin
        hold_cnt       = 64;
        hold_off_armed = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    while (cyc_count < CycleLimit) begin
      @(posedge clk);
      cyc_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    frame_res_t row_res;
    int         phase_start;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_tab[i]) begin
      row_res.out_byte   = directed_tab[i].out_byte;
      row_res.byte_valid = directed_tab[i].byte_valid;
      row_res.is_last    = directed_tab[i].is_last;
      send_byte(directed_tab[i].data, directed_tab[i].typed, row_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  hold_off_armed = 1'b1; end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + PhaseItems) send_message();
    end
    in_valid_i <= 1'b0;

    while (frame_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
